### hw/rtl/i2r_pkg.sv
// Shared types, constants and letter tables for the integer to Roman numeral unit.
package i2r_pkg;

  localparam int VALUE_W       = 12;
  localparam int SYMBOL_W      = 8;
  localparam int MAX_THOUSANDS = 3;
  localparam int VALUE_LIMIT   = MAX_THOUSANDS * 1000 + 999;

  // Largest thousands count that a value of VALUE_W bits can carry
  localparam int THOUS_TOP = ((1 << VALUE_W) - 1) / 1000;
  localparam int THOUS_W   = $clog2(THOUS_TOP + 1);
  localparam int DIGIT_W   = 4;
  localparam int REM1_W    = 10;  // remainder below 1000
  localparam int REM2_W    = 7;   // remainder below 100
  localparam int LEN_W     = 3;   // letters in one place, up to four
  localparam int IDX_W     = 2;   // letter index within one place

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Place codes, most significant first
  localparam logic [1:0] POS_THOUS = 2'd0;
  localparam logic [1:0] POS_HUND  = 2'd1;
  localparam logic [1:0] POS_TENS  = 2'd2;
  localparam logic [1:0] POS_UNITS = 2'd3;

  // Letter roles within one place
  localparam logic [1:0] SEL_ONE  = 2'd0;
  localparam logic [1:0] SEL_FIVE = 2'd1;
  localparam logic [1:0] SEL_NEXT = 2'd2;

  localparam logic [SYMBOL_W-1:0] CHAR_M = 8'h4D;
  localparam logic [SYMBOL_W-1:0] CHAR_D = 8'h44;
  localparam logic [SYMBOL_W-1:0] CHAR_C = 8'h43;
  localparam logic [SYMBOL_W-1:0] CHAR_L = 8'h4C;
  localparam logic [SYMBOL_W-1:0] CHAR_X = 8'h58;
  localparam logic [SYMBOL_W-1:0] CHAR_V = 8'h56;
  localparam logic [SYMBOL_W-1:0] CHAR_I = 8'h49;

  typedef struct packed {
    logic [THOUS_W-1:0] thous;
    logic [DIGIT_W-1:0] hund;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] units;
  } digits_t;

  typedef struct packed {
    logic              s1_valid;
    logic              s2_valid;
    logic [QCNT_W-1:0] q_level;
  } i2r_status_t;

  // Number of letters for one place; thousands are plain repeated M
  function automatic logic [LEN_W-1:0] run_len(input logic [1:0] pos,
                                               input logic [DIGIT_W-1:0] d);
    logic [LEN_W-1:0] n;
    n = '0;
    if (pos == POS_THOUS) begin
      n = LEN_W'(d);
    end else begin
      unique case (d)
        4'd0:                      n = 3'd0;
        4'd1, 4'd5:                n = 3'd1;
        4'd2, 4'd4, 4'd6, 4'd9:    n = 3'd2;
        4'd3, 4'd7:                n = 3'd3;
        4'd8:                      n = 3'd4;
        default:                   n = 3'd0;
      endcase
    end
    return n;
  endfunction

  // Letter at index k of the numeral for digit d in place pos
  function automatic logic [SYMBOL_W-1:0] place_symbol(input logic [1:0] pos,
                                                       input logic [DIGIT_W-1:0] d,
                                                       input logic [IDX_W-1:0] k);
    logic [1:0]          sel;
    logic [SYMBOL_W-1:0] ch;
    sel = SEL_ONE;
    ch  = CHAR_M;
    unique case (d)
      4'd4:                sel = (k == '0) ? SEL_ONE : SEL_FIVE;
      4'd5:                sel = SEL_FIVE;
      4'd6, 4'd7, 4'd8:    sel = (k == '0) ? SEL_FIVE : SEL_ONE;
      4'd9:                sel = (k == '0) ? SEL_ONE : SEL_NEXT;
      default:             sel = SEL_ONE;
    endcase
    unique case (pos)
      POS_THOUS: ch = CHAR_M;
      POS_HUND:  ch = (sel == SEL_ONE) ? CHAR_C : (sel == SEL_FIVE) ? CHAR_D : CHAR_M;
      POS_TENS:  ch = (sel == SEL_ONE) ? CHAR_X : (sel == SEL_FIVE) ? CHAR_L : CHAR_C;
      POS_UNITS: ch = (sel == SEL_ONE) ? CHAR_I : (sel == SEL_FIVE) ? CHAR_V : CHAR_X;
      default:   ch = CHAR_M;
    endcase
    return ch;
  endfunction

endpackage

### hw/rtl/i2r_front.sv
// Front end: range check and decimal split of each value over two stages.
module i2r_front import i2r_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [VALUE_W-1:0] value,
  output logic               full,
  output logic               q_push,
  output digits_t            q_data,
  input  logic               q_full,
  output logic               s1_valid,
  output logic               s2_valid
);

  logic [THOUS_W-1:0] s1_thous;
  logic [REM1_W-1:0]  s1_rem;
  logic [THOUS_W-1:0] s2_thous;
  logic [DIGIT_W-1:0] s2_hund;
  logic [REM2_W-1:0]  s2_rem;

  logic               accept;
  logic               in_range;
  logic               s1_move;
  logic [THOUS_W-1:0] thous_next;
  logic [REM1_W-1:0]  rem1_next;
  logic [DIGIT_W-1:0] hund_next;
  logic [REM2_W-1:0]  rem2_next;
  logic [DIGIT_W-1:0] tens_calc;
  logic [DIGIT_W-1:0] units_calc;

  assign in_range = (value != '0) && (int'(value) <= VALUE_LIMIT);
  assign q_push   = s2_valid && !q_full;
  assign s1_move  = s1_valid && (!s2_valid || q_push);
  assign full     = s1_valid && !s1_move;
  assign accept   = push && !full;

  always_comb begin
    thous_next = '0;
    for (int j = 1; j <= THOUS_TOP; j++) begin
      if (value >= VALUE_W'(j * 1000)) thous_next = THOUS_W'(j);
    end
    rem1_next = REM1_W'(value - VALUE_W'(thous_next) * VALUE_W'(1000));
  end

  always_comb begin
    hund_next = '0;
    for (int j = 1; j <= 9; j++) begin
      if (s1_rem >= REM1_W'(j * 100)) hund_next = DIGIT_W'(j);
    end
    rem2_next = REM2_W'(s1_rem - REM1_W'(hund_next) * REM1_W'(100));
  end

  always_comb begin
    tens_calc = '0;
    for (int j = 1; j <= 9; j++) begin
      if (s2_rem >= REM2_W'(j * 10)) tens_calc = DIGIT_W'(j);
    end
    units_calc = DIGIT_W'(s2_rem - REM2_W'(tens_calc) * REM2_W'(10));
  end

  assign q_data = '{thous: s2_thous, hund: s2_hund, tens: tens_calc, units: units_calc};

  // Zero and out-of-range values are dropped here and never reach the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= in_range;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_thous <= thous_next;
      s1_rem   <= rem1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
    end else if (q_push) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_thous <= s1_thous;
      s2_hund  <= hund_next;
      s2_rem   <= rem2_next;
    end
  end

endmodule

### hw/rtl/i2r_fifo.sv
// Short queue of split values between the front and back ends.
module i2r_fifo import i2r_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  digits_t           wdata,
  output logic              full,
  input  logic              pop,
  output digits_t           rdata,
  output logic              empty,
  output logic [QCNT_W-1:0] level
);

  digits_t           store [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign level   = count;
  assign rdata   = store[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/i2r_back.sv
// Back end: walk the places of one value and emit one letter per cycle while the result slot is free or popped.
module i2r_back import i2r_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  digits_t             q_data,
  input  logic                q_empty,
  output logic                q_pop,
  output logic [SYMBOL_W-1:0] symbol,
  output logic                last,
  output logic                empty,
  input  logic                pop
);

  digits_t          cur;
  logic             cur_valid;
  logic [1:0]       pos;
  logic [IDX_W-1:0] k;
  logic             ovalid;

  logic [3:0]         nz;
  logic [3:0]         later;
  logic [3:0]         head_nz;
  logic [DIGIT_W-1:0] d_sel;
  logic [LEN_W-1:0]   len;
  logic               digit_done;
  logic               is_last;
  logic               slot_free;
  logic               step;
  logic               load;

  function automatic logic [1:0] lowest(input logic [3:0] m);
    logic [1:0] p;
    p = POS_UNITS;
    priority if (m[0]) p = POS_THOUS;
    else if (m[1])     p = POS_HUND;
    else if (m[2])     p = POS_TENS;
    else               p = POS_UNITS;
    return p;
  endfunction

  always_comb begin
    unique case (pos)
      POS_THOUS: d_sel = DIGIT_W'(cur.thous);
      POS_HUND:  d_sel = cur.hund;
      POS_TENS:  d_sel = cur.tens;
      POS_UNITS: d_sel = cur.units;
      default:   d_sel = '0;
    endcase
  end

  assign nz      = {cur.units != '0, cur.tens != '0, cur.hund != '0, cur.thous != '0};
  assign head_nz = {q_data.units != '0, q_data.tens != '0, q_data.hund != '0,
                    q_data.thous != '0};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      later[i] = nz[i] && (2'(i) > pos);
    end
  end

  assign len        = run_len(pos, d_sel);
  assign digit_done = (LEN_W'(k) + LEN_W'(1)) == len;
  assign is_last    = digit_done && (later == '0);

  assign empty     = !ovalid;
  assign slot_free = !ovalid || pop;
  assign step      = cur_valid && slot_free;
  assign load      = !q_empty && (!cur_valid || (step && is_last));
  assign q_pop     = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      cur_valid <= 1'b1;
    end else if (step && is_last) begin
      cur_valid <= 1'b0;
    end
  end

  // Every queued value has at least one letter, so the first set place is real
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
      pos <= lowest(head_nz);
      k   <= '0;
    end else if (step) begin
      if (!digit_done) begin
        k <= k + IDX_W'(1);
      end else begin
        pos <= lowest(later);
        k   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (step) begin
      ovalid <= 1'b1;
    end else if (pop) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      symbol <= place_symbol(pos, d_sel, k);
      last   <= is_last;
    end
  end

endmodule

### hw/rtl/integer_to_roman_numeral_unit.sv
// Path: a value passes the two front-end stages, the queue, the back end's value register and
// the output register. Throughput: one letter per cycle while results are popped, up to fifteen
// letters per value; zero and out-of-range values take one front-end slot and emit nothing.
// The four-entry queue lets the front end keep taking values while the back end drains.
// Reset: synchronous; clears all valid flags and empties the queue, no clearing pass.
module integer_to_roman_numeral_unit import i2r_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [VALUE_W-1:0]  value,
  output logic                empty,
  input  logic                pop,
  output logic [SYMBOL_W-1:0] symbol,
  output logic                last
);

  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;
  digits_t     q_wdata;
  digits_t     q_rdata;
  i2r_status_t status;

  i2r_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .value    (value),
    .full     (full),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full),
    .s1_valid (status.s1_valid),
    .s2_valid (status.s2_valid)
  );

  i2r_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .level (status.q_level)
  );

  i2r_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .symbol  (symbol),
    .last    (last),
    .empty   (empty),
    .pop     (pop)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    status.q_level <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue level beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("front pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("back popped an empty queue");

  a_zero_dropped: assert property (@(posedge clk) disable iff (rst)
    (push && !full && value == '0) |=> !status.s1_valid)
    else $error("zero value entered the pipeline");

endmodule
